@@ rtl/kdsf_pkg.sv @@
// ----------------------------------------------------------------------------
// kdsf_pkg
// Shared types and constants for the keystroke to scancode type-ahead buffer.
// ----------------------------------------------------------------------------
package kdsf_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int CMDQ_DEPTH      = 2;
   localparam int WORD_W          = 16;

   typedef enum logic [1:0] {
      MODE_KEY  = 2'd0,
      MODE_TEXT = 2'd1,
      MODE_RAW  = 2'd2,
      MODE_READ = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_PUSH1 = 2'd1,
      OP_PUSH2 = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SECOND = 2'd1,
      ST_READ   = 2'd2
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [WORD_W-1:0]   word;
   } cmd_type;

endpackage

@@ rtl/keystroke_to_dos_scancode_fifo_top.sv @@
// ----------------------------------------------------------------------------
// keystroke_to_dos_scancode_fifo_top
// Type-ahead key buffer translating keyboard strokes into DOS getch() codes.
// ----------------------------------------------------------------------------
// Each request produces exactly one response. The front end classifies a
// request in the cycle it is taken and parks it in a two-entry command queue,
// so up to two further requests are taken while a response waits. The ring
// engine, with one write port and a registered read port on the entry memory,
// completes a dropped, ignored or single-word request and a read of an empty
// buffer straight from its idle state, and passes through a second state
// (ST_SECOND or ST_READ) for an extended key (prefix then scan byte) or for a
// read that returns an entry. The ring holds at most QUEUE_DEPTH-1 entries
// and needs no clearing after reset.
// ----------------------------------------------------------------------------
module keystroke_to_dos_scancode_fifo_top #(
   parameter int QUEUE_DEPTH = kdsf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_key_usage,
   input  logic               req_shift_held,
   input  logic               req_alt_held,
   input  logic [20:0]        req_char_code,
   input  logic signed [15:0] req_raw_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_read_value,
   output logic               rsp_read_valid,
   output logic               rsp_key_pending,
   output logic               rsp_dropped
);
   import kdsf_pkg::*;

   cmd_type  push_cmd, pop_cmd;
   logic     q_push, q_not_full, q_pop_valid, q_pop;

   kdsf_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_key_usage  (req_key_usage),
      .req_shift_held (req_shift_held),
      .req_alt_held   (req_alt_held),
      .req_char_code  (req_char_code),
      .req_raw_value  (req_raw_value),
      .q_not_full     (q_not_full),
      .q_push         (q_push),
      .q_cmd          (push_cmd)
   );

   kdsf_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .not_full  (q_not_full),
      .pop_valid (q_pop_valid),
      .pop       (q_pop),
      .pop_cmd   (pop_cmd)
   );

   kdsf_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (q_pop_valid),
      .cmd             (pop_cmd),
      .cmd_pop         (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_read_valid  (rsp_read_valid),
      .rsp_key_pending (rsp_key_pending),
      .rsp_dropped     (rsp_dropped)
   );

endmodule

@@ rtl/kdsf_front.sv @@
// ----------------------------------------------------------------------------
// kdsf_front
// Accepts requests and classifies them into buffer commands: key translation
// to DOS codes, printable text filter, raw words and reads.
// ----------------------------------------------------------------------------
module kdsf_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_mode,
   input  logic [7:0]        req_key_usage,
   input  logic              req_shift_held,
   input  logic              req_alt_held,
   input  logic [20:0]       req_char_code,
   input  logic signed [15:0] req_raw_value,
   input  logic              q_not_full,
   output logic              q_push,
   output kdsf_pkg::cmd_type q_cmd
);
   import kdsf_pkg::*;

   localparam logic [7:0] HID_E      = 8'h08;
   localparam logic [7:0] HID_T      = 8'h17;
   localparam logic [7:0] HID_V      = 8'h19;
   localparam logic [7:0] HID_F1     = 8'h3A;
   localparam logic [7:0] HID_F10    = 8'h43;
   localparam logic [7:0] HID_UP     = 8'h52;
   localparam logic [7:0] HID_DOWN   = 8'h51;
   localparam logic [7:0] HID_LEFT   = 8'h50;
   localparam logic [7:0] HID_RIGHT  = 8'h4F;
   localparam logic [7:0] HID_HOME   = 8'h4A;
   localparam logic [7:0] HID_END    = 8'h4D;
   localparam logic [7:0] HID_PGUP   = 8'h4B;
   localparam logic [7:0] HID_PGDN   = 8'h4E;
   localparam logic [7:0] HID_INS    = 8'h49;
   localparam logic [7:0] HID_DEL    = 8'h4C;
   localparam logic [7:0] HID_ESC    = 8'h29;
   localparam logic [7:0] HID_ENTER  = 8'h28;
   localparam logic [7:0] HID_BKSP   = 8'h2A;
   localparam logic [7:0] HID_TAB    = 8'h2B;
   localparam logic [7:0] SCAN_F1    = 8'h3B;
   localparam logic [7:0] SCAN_SF1   = 8'h54;
   localparam logic [20:0] TEXT_LO   = 21'h20;
   localparam logic [20:0] TEXT_HI   = 21'h7E;

   logic [15:0] code;
   logic [7:0]  fkey_scan;

   assign fkey_scan = (req_shift_held ? SCAN_SF1 : SCAN_F1) + (req_key_usage - HID_F1);

   always_comb begin
      code = 16'h0000;
      if (req_alt_held) begin
         unique case (req_key_usage)
            HID_E:   code = 16'h1200;
            HID_T:   code = 16'h1400;
            HID_V:   code = 16'h2F00;
            default: code = 16'h0000;
         endcase
      end else if (req_key_usage >= HID_F1 && req_key_usage <= HID_F10) begin
         code = {fkey_scan, 8'h00};
      end else begin
         unique case (req_key_usage)
            HID_UP:    code = 16'h4800;
            HID_DOWN:  code = 16'h5000;
            HID_LEFT:  code = 16'h4B00;
            HID_RIGHT: code = 16'h4D00;
            HID_HOME:  code = 16'h4700;
            HID_END:   code = 16'h4F00;
            HID_PGUP:  code = 16'h4900;
            HID_PGDN:  code = 16'h5100;
            HID_INS:   code = 16'h5200;
            HID_DEL:   code = 16'h5300;
            HID_ESC:   code = 16'd27;
            HID_ENTER: code = 16'd13;
            HID_BKSP:  code = 16'd8;
            HID_TAB:   code = 16'd9;
            default:   code = 16'h0000;
         endcase
      end
   end

   always_comb begin
      q_cmd.op   = OP_NONE;
      q_cmd.word = '0;
      unique case (mode_type'(req_mode))
         MODE_KEY: begin
            if (code[15:8] != 8'h00) begin
               q_cmd.op   = OP_PUSH2;
               q_cmd.word = {8'h00, code[15:8]};
            end else if (code != 16'h0000) begin
               q_cmd.op   = OP_PUSH1;
               q_cmd.word = code;
            end
         end
         MODE_TEXT: begin
            if (req_char_code >= TEXT_LO && req_char_code <= TEXT_HI) begin
               q_cmd.op   = OP_PUSH1;
               q_cmd.word = req_char_code[15:0];
            end
         end
         MODE_RAW: begin
            q_cmd.op   = OP_PUSH1;
            q_cmd.word = req_raw_value;
         end
         MODE_READ: begin
            q_cmd.op = OP_READ;
         end
         default: begin
            q_cmd.op = OP_NONE;
         end
      endcase
   end

   assign req_ready = q_not_full;
   assign q_push    = req_valid && q_not_full;

endmodule

@@ rtl/kdsf_cmdq.sv @@
// ----------------------------------------------------------------------------
// kdsf_cmdq
// Short command queue between the classifier and the ring buffer engine.
// ----------------------------------------------------------------------------
module kdsf_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kdsf_pkg::cmd_type push_cmd,
   output logic              not_full,
   output logic              pop_valid,
   input  logic              pop,
   output kdsf_pkg::cmd_type pop_cmd
);
   import kdsf_pkg::*;

   localparam int QPTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int QCNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type             slot_ff [CMDQ_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   function automatic logic [QPTR_W-1:0] qptr_inc(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      r = (p == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   assign not_full  = (count_ff != QCNT_W'(CMDQ_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push && not_full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? qptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? qptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/kdsf_back.sv @@
// ----------------------------------------------------------------------------
// kdsf_back
// Ring buffer engine: executes pushes, extended-key pairs and reads against
// the entry memory and holds the response register.
// ----------------------------------------------------------------------------
module kdsf_back #(
   parameter int QUEUE_DEPTH = kdsf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  kdsf_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [15:0] rsp_read_value,
   output logic              rsp_read_valid,
   output logic              rsp_key_pending,
   output logic              rsp_dropped
);
   import kdsf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic [WORD_W-1:0]  mem [QUEUE_DEPTH];
   logic [WORD_W-1:0]  rd_data_ff;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [WORD_W-1:0]  second_ff, second_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_read_value_ff, rsp_read_value_in;
   logic               rsp_read_valid_ff, rsp_read_valid_in;
   logic               rsp_key_pending_ff, rsp_key_pending_in;
   logic               rsp_dropped_ff, rsp_dropped_in;

   logic               slot_free, start;
   logic               empty, full, short2;
   logic [PTR_W-1:0]   tail_next1, tail_next2, head_next1;
   logic               mem_we, rd_en;
   logic [WORD_W-1:0]  mem_wdata;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   assign tail_next1 = ptr_inc(tail_ff);
   assign tail_next2 = ptr_inc(tail_next1);
   assign head_next1 = ptr_inc(head_ff);
   assign empty      = (head_ff == tail_ff);
   assign full       = (tail_next1 == head_ff);
   assign short2     = full || (tail_next2 == head_ff);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign start      = (state_ff == ST_IDLE) && cmd_valid && slot_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && cmd.op == OP_PUSH2 && !short2) begin
               state_in = ST_SECOND;
            end else if (start && cmd.op == OP_READ && !empty) begin
               state_in = ST_READ;
            end
         end
         ST_SECOND: state_in = ST_IDLE;
         ST_READ:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and response
   always_comb begin
      cmd_pop            = 1'b0;
      mem_we             = 1'b0;
      mem_wdata          = '0;
      rd_en              = 1'b0;
      head_in            = head_ff;
      tail_in            = tail_ff;
      second_in          = second_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_read_valid_in  = rsp_read_valid_ff;
      rsp_key_pending_in = rsp_key_pending_ff;
      rsp_dropped_in     = rsp_dropped_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  OP_NONE: begin
                     rsp_valid_in       = 1'b1;
                     rsp_read_value_in  = '0;
                     rsp_read_valid_in  = 1'b0;
                     rsp_key_pending_in = !empty;
                     rsp_dropped_in     = 1'b0;
                  end
                  OP_PUSH1: begin
                     rsp_valid_in      = 1'b1;
                     rsp_read_value_in = '0;
                     rsp_read_valid_in = 1'b0;
                     if (full) begin
                        rsp_key_pending_in = !empty;
                        rsp_dropped_in     = 1'b1;
                     end else begin
                        mem_we             = 1'b1;
                        mem_wdata          = cmd.word;
                        tail_in            = tail_next1;
                        rsp_key_pending_in = 1'b1;
                        rsp_dropped_in     = 1'b0;
                     end
                  end
                  OP_PUSH2: begin
                     if (short2) begin
                        rsp_valid_in       = 1'b1;
                        rsp_read_value_in  = '0;
                        rsp_read_valid_in  = 1'b0;
                        rsp_key_pending_in = !empty;
                        rsp_dropped_in     = 1'b1;
                     end else begin
                        mem_we    = 1'b1;
                        mem_wdata = '0;
                        tail_in   = tail_next1;
                        second_in = cmd.word;
                     end
                  end
                  OP_READ: begin
                     if (empty) begin
                        rsp_valid_in       = 1'b1;
                        rsp_read_value_in  = '0;
                        rsp_read_valid_in  = 1'b0;
                        rsp_key_pending_in = 1'b0;
                        rsp_dropped_in     = 1'b0;
                     end else begin
                        rd_en   = 1'b1;
                        head_in = head_next1;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_SECOND: begin
            mem_we             = 1'b1;
            mem_wdata          = second_ff;
            tail_in            = tail_next1;
            rsp_valid_in       = 1'b1;
            rsp_read_value_in  = '0;
            rsp_read_valid_in  = 1'b0;
            rsp_key_pending_in = 1'b1;
            rsp_dropped_in     = 1'b0;
         end
         ST_READ: begin
            rsp_valid_in       = 1'b1;
            rsp_read_value_in  = rd_data_ff;
            rsp_read_valid_in  = 1'b1;
            rsp_key_pending_in = !empty;
            rsp_dropped_in     = 1'b0;
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      second_ff          <= second_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_read_valid_ff  <= rsp_read_valid_in;
      rsp_key_pending_ff <= rsp_key_pending_in;
      rsp_dropped_ff     <= rsp_dropped_in;
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail_ff] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_read_valid  = rsp_read_valid_ff;
   assign rsp_key_pending = rsp_key_pending_ff;
   assign rsp_dropped     = rsp_dropped_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !full)
      else $error("ring written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty)
      else $error("ring read while empty");

   a_read_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> rsp_valid_ff && rsp_read_valid_ff && !rsp_dropped_ff)
      else $error("read did not produce a valid entry");

   a_second_from_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SECOND |-> $past(state_ff) == ST_IDLE && $past(mem_we))
      else $error("extended pair second write without its prefix");

endmodule

@@ dv/kdsf_checker.sv @@
// ----------------------------------------------------------------------------
// kdsf_checker
// Watches the request and response channels of the type-ahead key buffer,
// keeps its own copy of the ring, predicts the response of every accepted
// request and compares each accepted response field by field, in order.
// ----------------------------------------------------------------------------
module kdsf_checker #(
   parameter int QUEUE_DEPTH = kdsf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_key_usage,
   input  logic               req_shift_held,
   input  logic               req_alt_held,
   input  logic [20:0]        req_char_code,
   input  logic signed [15:0] req_raw_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_read_value,
   input  logic               rsp_read_valid,
   input  logic               rsp_key_pending,
   input  logic               rsp_dropped,
   output int                 fail_count,
   output int                 pending_count
);
   import kdsf_pkg::*;

   localparam logic [7:0] HID_E         = 8'h08;
   localparam logic [7:0] HID_T         = 8'h17;
   localparam logic [7:0] HID_V         = 8'h19;
   localparam logic [7:0] HID_F1        = 8'h3A;
   localparam logic [7:0] HID_F10       = 8'h43;
   localparam logic [7:0] SCAN_F1       = 8'h3B;
   localparam logic [7:0] SCAN_SHIFT_F1 = 8'h54;

   typedef struct {
      logic signed [15:0] read_value;
      logic               read_valid;
      logic               key_pending;
      logic               dropped;
   } outcome_type;

   outcome_type expected_q[$];
   logic [15:0] ring [QUEUE_DEPTH];
   int unsigned head_ptr = 0;
   int unsigned tail_ptr = 0;
   int          errors   = 0;

   function automatic logic [15:0] dos_key_code(input logic [7:0] usage, input logic shift,
                                                input logic alt);
      logic [7:0] scan;
      if (alt) begin
         case (usage)
            HID_E:   return 16'h1200;
            HID_T:   return 16'h1400;
            HID_V:   return 16'h2F00;
            default: return 16'h0000;
         endcase
      end
      if (usage >= HID_F1 && usage <= HID_F10) begin
         scan = (shift ? SCAN_SHIFT_F1 : SCAN_F1) + (usage - HID_F1);
         return {scan, 8'h00};
      end
      case (usage)
         8'h52:   return 16'h4800;
         8'h51:   return 16'h5000;
         8'h50:   return 16'h4B00;
         8'h4F:   return 16'h4D00;
         8'h4A:   return 16'h4700;
         8'h4D:   return 16'h4F00;
         8'h4B:   return 16'h4900;
         8'h4E:   return 16'h5100;
         8'h49:   return 16'h5200;
         8'h4C:   return 16'h5300;
         8'h29:   return 16'd27;
         8'h28:   return 16'd13;
         8'h2A:   return 16'd8;
         8'h2B:   return 16'd9;
         default: return 16'h0000;
      endcase
   endfunction

   function automatic int unsigned ring_room();
      return (head_ptr + QUEUE_DEPTH - tail_ptr - 1) % QUEUE_DEPTH;
   endfunction

   // returns 1 when the ring is full and the word is refused
   function automatic logic enqueue_word(input logic [15:0] w);
      if ((tail_ptr + 1) % QUEUE_DEPTH == head_ptr) return 1'b1;
      ring[tail_ptr] = w;
      tail_ptr       = (tail_ptr + 1) % QUEUE_DEPTH;
      return 1'b0;
   endfunction

   task automatic predict_response(input mode_type m, input logic [7:0] usage,
                                   input logic shift, input logic alt,
                                   input logic [20:0] cp, input logic [15:0] raw);
      outcome_type o;
      logic [15:0] code;
      o.read_value  = '0;
      o.read_valid  = 1'b0;
      o.dropped     = 1'b0;
      case (m)
         MODE_KEY: begin
            code = dos_key_code(usage, shift, alt);
            if (code[15:8] != 8'h00) begin
               if (ring_room() < 2) begin
                  o.dropped = 1'b1;
               end else begin
                  void'(enqueue_word(16'h0000));
                  void'(enqueue_word({8'h00, code[15:8]}));
               end
            end else if (code != 16'h0000) begin
               o.dropped = enqueue_word(code);
            end
         end
         MODE_TEXT: begin
            if (cp >= 21'h20 && cp <= 21'h7E) o.dropped = enqueue_word(cp[15:0]);
         end
         MODE_RAW: begin
            o.dropped = enqueue_word(raw);
         end
         default: begin
            if (head_ptr != tail_ptr) begin
               o.read_value = ring[head_ptr];
               o.read_valid = 1'b1;
               head_ptr     = (head_ptr + 1) % QUEUE_DEPTH;
            end
         end
      endcase
      o.key_pending = (head_ptr != tail_ptr);
      expected_q.push_back(o);
   endtask

   task automatic report(input string field, input int expv, input int actv);
      $display("%0t: %s expected %0d actual %0d", $time, field, expv, actv);
      errors++;
   endtask

   always @(posedge clock) begin : monitor
      outcome_type want;
      if (reset) begin
         expected_q.delete();
         head_ptr = 0;
         tail_ptr = 0;
      end else begin
         // response first: it can never belong to a request taken at this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: response with nothing outstanding, expected none actual %0d",
                        $time, rsp_read_value);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_read_value !== want.read_value)
                  report("read_value", want.read_value, rsp_read_value);
               if (rsp_read_valid !== want.read_valid)
                  report("read_valid", want.read_valid, rsp_read_valid);
               if (rsp_key_pending !== want.key_pending)
                  report("key_pending", want.key_pending, rsp_key_pending);
               if (rsp_dropped !== want.dropped)
                  report("dropped", want.dropped, rsp_dropped);
            end
         end
         if (req_valid && req_ready)
            predict_response(mode_type'(req_mode), req_key_usage, req_shift_held,
                             req_alt_held, req_char_code, req_raw_value);
      end
      fail_count    <= errors;
      pending_count <= expected_q.size();
   end

endmodule

@@ dv/tb_keystroke_to_dos_scancode_fifo_top.sv @@
// ----------------------------------------------------------------------------
// tb_keystroke_to_dos_scancode_fifo_top
// Drives directed and random requests into the type-ahead key buffer with
// random gaps and response stalls, including two long response hold-offs,
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_keystroke_to_dos_scancode_fifo_top;
   import kdsf_pkg::*;

   localparam int RANDOM_ITEMS   = 1000;
   localparam int HOLD_CYCLES    = 150;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 2000;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode        = MODE_KEY;
   logic [7:0]         req_key_usage   = '0;
   logic               req_shift_held  = 1'b0;
   logic               req_alt_held    = 1'b0;
   logic [20:0]        req_char_code   = '0;
   logic signed [15:0] req_raw_value   = '0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic signed [15:0] rsp_read_value;
   logic               rsp_read_valid;
   logic               rsp_key_pending;
   logic               rsp_dropped;

   int   fail_count;
   int   pending_count;
   int   quiet_cycles  = 0;
   logic send_burst    = 1'b0;
   logic hold_off_due  = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   keystroke_to_dos_scancode_fifo_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_key_usage   (req_key_usage),
      .req_shift_held  (req_shift_held),
      .req_alt_held    (req_alt_held),
      .req_char_code   (req_char_code),
      .req_raw_value   (req_raw_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_read_valid  (rsp_read_valid),
      .rsp_key_pending (rsp_key_pending),
      .rsp_dropped     (rsp_dropped)
   );

   kdsf_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_key_usage   (req_key_usage),
      .req_shift_held  (req_shift_held),
      .req_alt_held    (req_alt_held),
      .req_char_code   (req_char_code),
      .req_raw_value   (req_raw_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_read_valid  (rsp_read_valid),
      .rsp_key_pending (rsp_key_pending),
      .rsp_dropped     (rsp_dropped),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input mode_type m, input logic [7:0] usage, input logic shift,
                               input logic alt, input logic [20:0] cp,
                               input logic [15:0] raw);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode       <= m;
      req_key_usage  <= usage;
      req_shift_held <= shift;
      req_alt_held   <= alt;
      req_char_code  <= cp;
      req_raw_value  <= raw;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : receiver
      int   stall;
      logic rsp_burst;
      logic hold_off_seen;
      rsp_burst     = 1'b0;
      hold_off_seen = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_due != hold_off_seen) begin
            hold_off_seen = hold_off_due;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if ($urandom_range(0, 29) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      mode_type    m;
      logic [7:0]  usage;
      logic        shift;
      logic        alt;
      logic [20:0] cp;
      logic        filling;
      int          phase_left;
      int          pick;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed
      send_request(MODE_READ, 8'h00, 1'b0, 1'b0, 21'h0, 16'h0000);
      send_request(MODE_KEY,  8'h3A, 1'b0, 1'b0, 21'h0, 16'h0000);
      send_request(MODE_KEY,  8'h43, 1'b1, 1'b0, 21'h0, 16'h0000);
      send_request(MODE_KEY,  8'h3A, 1'b1, 1'b0, 21'h0, 16'h0000);
      send_request(MODE_KEY,  8'h08, 1'b0, 1'b1, 21'h0, 16'h0000);
      send_request(MODE_KEY,  8'h17, 1'b1, 1'b1, 21'h0, 16'h0000);
      send_request(MODE_KEY,  8'h19, 1'b0, 1'b1, 21'h0, 16'h0000);
      send_request(MODE_KEY,  8'h3A, 1'b0, 1'b1, 21'h0, 16'h0000);
      send_request(MODE_KEY,  8'h00, 1'b0, 1'b0, 21'h0, 16'h0000);
      send_request(MODE_KEY,  8'hFF, 1'b1, 1'b0, 21'h1FFFFF, 16'hFFFF);
      send_request(MODE_KEY,  8'h29, 1'b0, 1'b0, 21'h0, 16'h0000);
      send_request(MODE_KEY,  8'h28, 1'b0, 1'b0, 21'h0, 16'h0000);
      send_request(MODE_KEY,  8'h2A, 1'b0, 1'b0, 21'h0, 16'h0000);
      send_request(MODE_KEY,  8'h2B, 1'b0, 1'b0, 21'h0, 16'h0000);
      send_request(MODE_KEY,  8'h52, 1'b0, 1'b0, 21'h0, 16'h0000);
      send_request(MODE_KEY,  8'h4C, 1'b0, 1'b0, 21'h0, 16'h0000);
      send_request(MODE_TEXT, 8'h00, 1'b0, 1'b0, 21'h20, 16'h0000);
      send_request(MODE_TEXT, 8'h00, 1'b0, 1'b0, 21'h7E, 16'h0000);
      send_request(MODE_TEXT, 8'h00, 1'b0, 1'b0, 21'h1F, 16'h0000);
      send_request(MODE_TEXT, 8'h00, 1'b0, 1'b0, 21'h7F, 16'h0000);
      send_request(MODE_TEXT, 8'hFF, 1'b1, 1'b1, 21'h1FFFFF, 16'hFFFF);
      send_request(MODE_RAW,  8'h00, 1'b0, 1'b0, 21'h0, 16'h8000);
      send_request(MODE_RAW,  8'h00, 1'b0, 1'b0, 21'h0, 16'h7FFF);
      send_request(MODE_READ, 8'hFF, 1'b1, 1'b1, 21'h1FFFFF, 16'hFFFF);
      send_request(MODE_READ, 8'h00, 1'b0, 1'b0, 21'h0, 16'h0000);

      // random: alternate fill and drain phases so the ring runs full and empty
      filling    = 1'b1;
      phase_left = $urandom_range(40, 120);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
         if (phase_left == 0) begin
            filling    = !filling;
            phase_left = $urandom_range(40, 120);
         end
         phase_left--;
         if (n == 300 || n == 700) hold_off_due = !hold_off_due;

         pick = $urandom_range(0, 99);
         if (filling ? (pick < 15) : (pick < 75)) begin
            m = MODE_READ;
         end else begin
            case ($urandom_range(0, 2))
               0:       m = MODE_KEY;
               1:       m = MODE_TEXT;
               default: m = MODE_RAW;
            endcase
         end

         shift = 1'($urandom_range(0, 1));
         alt   = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 0) begin
            usage = 8'($urandom);
         end else begin
            case ($urandom_range(0, 3))
               0:       usage = 8'h3A + 8'($urandom_range(0, 9));
               1:       usage = 8'h49 + 8'($urandom_range(0, 9));
               2:       usage = 8'h28 + 8'($urandom_range(0, 3));
               default: begin
                  case ($urandom_range(0, 2))
                     0:       usage = 8'h08;
                     1:       usage = 8'h17;
                     default: usage = 8'h19;
                  endcase
                  alt = ($urandom_range(0, 3) != 0);
               end
            endcase
         end

         case ($urandom_range(0, 2))
            0:       cp = 21'($urandom_range(32'h20, 32'h7E));
            1:       cp = 21'($urandom_range(0, 32'h9F));
            default: cp = 21'($urandom);
         endcase

         send_request(m, usage, shift, alt, cp, 16'($urandom));
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
